// ===== rtl/core/difference_vector_index_lookup_assert.svh =====
// assertion helpers for the difference vector index lookup
`ifndef DIFFERENCE_VECTOR_INDEX_LOOKUP_ASSERT_SVH
`define DIFFERENCE_VECTOR_INDEX_LOOKUP_ASSERT_SVH

// implication checked at every clock edge outside reset
`define DVIL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define DVIL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dvil_pkg.sv =====
package dvil_pkg;

   localparam int WAVE_DEPTH_DEF     = 64;
   localparam int TRANSFER_DEPTH_DEF = 512;
   localparam int COMP_BITS_DEF      = 8;

   localparam int IDX_BITS     = 9;
   localparam int IN_COMP_BITS = 8;
   localparam int WCOUNT_BITS  = 7;
   localparam int TCOUNT_BITS  = 10;
   localparam int CSR_DATA_BITS = 10;
   localparam int CSR_IDX_BITS  = 1;

   typedef enum logic [1:0] {
      KIND_LOAD_WAVE = 2'd0,
      KIND_LOAD_XFER = 2'd1,
      KIND_SEARCH_WT = 2'd2,
      KIND_SEARCH_WW = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WAVE_COUNT = 1'd0,
      CSR_XFER_COUNT = 1'd1
   } csr_idx_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD_A = 6'b000010,
      ST_RD_B = 6'b000100,
      ST_DIFF = 6'b001000,
      ST_SCAN = 6'b010000,
      ST_RESP = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/dvil_ram.sv =====
module dvil_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/difference_vector_index_lookup.sv =====
// Keeps a wave table and a transfer table of signed 3D vectors in two single-port-read
// memories. Kind 0 and 1 items load one entry. Kind 2 forms wave[a] - transfer[b] and
// scans the wave table; kind 3 forms wave[a] - wave[b] and scans the transfer table; each
// returns the lowest matching index or found = 0. A search's scan reads the entries up to
// and including the first hit, or the whole effective count of the scanned table when
// nothing matches. The scan reads one entry per cycle through the memory's one read port,
// and the two operands are fetched one after the other. A search with an operand index
// out of range skips the table reads and goes straight to the response state. Loads and
// searches are taken only while no search is in progress; a finished result waits in the
// output register while the next item is taken, and a search that finishes while the
// previous result is still stalled waits for that result's transfer.
`include "difference_vector_index_lookup_assert.svh"

module difference_vector_index_lookup #(
   parameter int WAVE_DEPTH     = dvil_pkg::WAVE_DEPTH_DEF,
   parameter int TRANSFER_DEPTH = dvil_pkg::TRANSFER_DEPTH_DEF,
   parameter int COMP_BITS      = dvil_pkg::COMP_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_kind,
   input  logic [dvil_pkg::IDX_BITS-1:0]         req_first_index,
   input  logic [dvil_pkg::IDX_BITS-1:0]         req_second_index,
   input  logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_x,
   input  logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_y,
   input  logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [dvil_pkg::IDX_BITS-1:0]         rsp_match_index,
   input  logic                                  csr_write,
   input  logic [dvil_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [dvil_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int WAVE_AW = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
   localparam int XFER_AW = (TRANSFER_DEPTH > 1) ? $clog2(TRANSFER_DEPTH) : 1;
   localparam int WCW     = $clog2(WAVE_DEPTH + 1);
   localparam int TCW     = $clog2(TRANSFER_DEPTH + 1);
   localparam int SCW     = (WCW > TCW) ? WCW : TCW;
   localparam int VW      = 3 * COMP_BITS;
   localparam int DW      = COMP_BITS + 1;

   // configuration
   logic [dvil_pkg::WCOUNT_BITS-1:0] wave_count_ff;
   logic [dvil_pkg::TCOUNT_BITS-1:0] xfer_count_ff;
   logic [WCW-1:0] nw;
   logic [TCW-1:0] nt;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_count_ff <= '0;
         xfer_count_ff <= '0;
      end else if (csr_write) begin
         unique case (dvil_pkg::csr_idx_type'(csr_index))
            dvil_pkg::CSR_WAVE_COUNT: begin
               wave_count_ff <= csr_wdata[dvil_pkg::WCOUNT_BITS-1:0];
            end
            dvil_pkg::CSR_XFER_COUNT: begin
               xfer_count_ff <= csr_wdata[dvil_pkg::TCOUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign nw = (32'(wave_count_ff) > WAVE_DEPTH) ? WCW'(WAVE_DEPTH) : WCW'(wave_count_ff);
   assign nt = (32'(xfer_count_ff) > TRANSFER_DEPTH) ? TCW'(TRANSFER_DEPTH)
                                                      : TCW'(xfer_count_ff);

   // control and datapath registers
   dvil_pkg::state_type state_ff, state_in;
   dvil_pkg::kind_type  kind_ff, kind_in;
   logic [dvil_pkg::IDX_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [VW-1:0]       minu_ff, minu_in;
   logic [3*DW-1:0]     diff_ff, diff_in;
   logic [SCW-1:0]      scan_idx_ff, scan_idx_in, chk_ff, chk_in;
   logic                data_vld_ff, data_vld_in;
   logic                res_found_ff, res_found_in;
   logic [SCW-1:0]      res_idx_ff, res_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [dvil_pkg::IDX_BITS-1:0] rsp_idx_ff, rsp_idx_in;

   logic req_xfer;
   logic rsp_xfer;
   logic [VW-1:0] wave_rdata, xfer_rdata, scan_rdata, sub_rdata;
   logic [SCW-1:0] scan_lim;
   logic hit;
   logic [2:0] comp_eq;
   logic [3*DW-1:0] diff_calc;
   logic [31:0] a_wide, b_wide, scan_wide, res_wide, req_a_wide;
   logic signed [31:0] ld_x, ld_y, ld_z;
   logic [VW-1:0] ld_data;
   logic range_ok;

   assign req_stall = (state_ff != dvil_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // loaded components: sign-extend, then wrap to the stored width
   assign ld_x    = 32'(req_comp_x);
   assign ld_y    = 32'(req_comp_y);
   assign ld_z    = 32'(req_comp_z);
   assign ld_data = {ld_z[COMP_BITS-1:0], ld_y[COMP_BITS-1:0], ld_x[COMP_BITS-1:0]};

   assign req_a_wide = 32'(req_first_index);
   assign a_wide     = 32'(a_ff);
   assign b_wide     = 32'(b_ff);
   assign scan_wide  = 32'(scan_idx_ff);
   assign res_wide   = 32'(res_idx_ff);

   // memories
   logic               wave_we, xfer_we;
   logic [WAVE_AW-1:0] wave_raddr;
   logic [XFER_AW-1:0] xfer_raddr;

   assign wave_we = req_xfer && (dvil_pkg::kind_type'(req_kind) == dvil_pkg::KIND_LOAD_WAVE)
                    && (req_a_wide < WAVE_DEPTH);
   assign xfer_we = req_xfer && (dvil_pkg::kind_type'(req_kind) == dvil_pkg::KIND_LOAD_XFER)
                    && (req_a_wide < TRANSFER_DEPTH);

   always_comb begin
      wave_raddr = scan_wide[WAVE_AW-1:0];
      xfer_raddr = scan_wide[XFER_AW-1:0];
      if (state_ff == dvil_pkg::ST_RD_A) begin
         wave_raddr = a_wide[WAVE_AW-1:0];
      end else if (state_ff == dvil_pkg::ST_RD_B) begin
         wave_raddr = b_wide[WAVE_AW-1:0];
         xfer_raddr = b_wide[XFER_AW-1:0];
      end
   end

   dvil_ram #(.WIDTH(VW), .DEPTH(WAVE_DEPTH)) u_wave_ram (
      .clock   (clock),
      .wr_en   (wave_we),
      .wr_addr (req_a_wide[WAVE_AW-1:0]),
      .wr_data (ld_data),
      .rd_addr (wave_raddr),
      .rd_data (wave_rdata)
   );

   dvil_ram #(.WIDTH(VW), .DEPTH(TRANSFER_DEPTH)) u_xfer_ram (
      .clock   (clock),
      .wr_en   (xfer_we),
      .wr_addr (req_a_wide[XFER_AW-1:0]),
      .wr_data (ld_data),
      .rd_addr (xfer_raddr),
      .rd_data (xfer_rdata)
   );

   // kind 2 subtracts a transfer vector and scans waves; kind 3 the other way round
   assign sub_rdata  = (kind_ff == dvil_pkg::KIND_SEARCH_WT) ? xfer_rdata : wave_rdata;
   assign scan_rdata = (kind_ff == dvil_pkg::KIND_SEARCH_WT) ? wave_rdata : xfer_rdata;
   assign scan_lim   = (kind_ff == dvil_pkg::KIND_SEARCH_WT) ? SCW'(nw) : SCW'(nt);

   always_comb begin
      logic signed [COMP_BITS-1:0] mc;
      logic signed [COMP_BITS-1:0] sc;
      logic signed [COMP_BITS-1:0] tc;
      for (int k = 0; k < 3; k++) begin
         mc = signed'(minu_ff[k*COMP_BITS +: COMP_BITS]);
         sc = signed'(sub_rdata[k*COMP_BITS +: COMP_BITS]);
         tc = signed'(scan_rdata[k*COMP_BITS +: COMP_BITS]);
         diff_calc[k*DW +: DW] = DW'(mc) - DW'(sc);
         comp_eq[k] = (DW'(tc) == diff_ff[k*DW +: DW]);
      end
   end

   assign hit = data_vld_ff && (&comp_eq);

   // operand range check on the incoming search
   always_comb begin
      if (dvil_pkg::kind_type'(req_kind) == dvil_pkg::KIND_SEARCH_WT) begin
         range_ok = (32'(req_first_index) < 32'(nw)) && (32'(req_second_index) < 32'(nt));
      end else begin
         range_ok = (32'(req_first_index) < 32'(nw)) && (32'(req_second_index) < 32'(nw));
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      minu_in      = minu_ff;
      diff_in      = diff_ff;
      scan_idx_in  = scan_idx_ff;
      chk_in       = chk_ff;
      data_vld_in  = data_vld_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;

      unique case (state_ff)
         dvil_pkg::ST_IDLE: begin
            if (req_xfer && req_kind[1]) begin
               kind_in = dvil_pkg::kind_type'(req_kind);
               a_in    = req_first_index;
               b_in    = req_second_index;
               if (range_ok) begin
                  state_in = dvil_pkg::ST_RD_A;
               end else begin
                  res_found_in = 1'b0;
                  res_idx_in   = '0;
                  state_in     = dvil_pkg::ST_RESP;
               end
            end
         end
         dvil_pkg::ST_RD_A: begin
            state_in = dvil_pkg::ST_RD_B;
         end
         dvil_pkg::ST_RD_B: begin
            minu_in  = wave_rdata;
            state_in = dvil_pkg::ST_DIFF;
         end
         dvil_pkg::ST_DIFF: begin
            // difference held for the whole scan
            diff_in     = diff_calc;
            scan_idx_in = '0;
            data_vld_in = 1'b0;
            state_in    = dvil_pkg::ST_SCAN;
         end
         dvil_pkg::ST_SCAN: begin
            if (hit) begin
               res_found_in = 1'b1;
               res_idx_in   = chk_ff;
               state_in     = dvil_pkg::ST_RESP;
            end else if (scan_idx_ff < scan_lim) begin
               // read issued this cycle, compared on the next
               chk_in      = scan_idx_ff;
               scan_idx_in = SCW'(scan_idx_ff + 1'b1);
               data_vld_in = 1'b1;
            end else begin
               res_found_in = 1'b0;
               res_idx_in   = '0;
               state_in     = dvil_pkg::ST_RESP;
            end
         end
         dvil_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_idx_in   = res_wide[dvil_pkg::IDX_BITS-1:0];
               state_in     = dvil_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dvil_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvil_pkg::ST_IDLE;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      minu_ff      <= minu_in;
      diff_ff      <= diff_in;
      scan_idx_ff  <= scan_idx_in;
      chk_ff       <= chk_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;

   `DVIL_ASSERT_NEXT(a_rsp_from_resp, !rsp_valid_ff, !rsp_valid_ff || $past(state_ff == dvil_pkg::ST_RESP), "result shown without a finished search")
   `DVIL_ASSERT_IMPL(a_scan_bound, state_ff == dvil_pkg::ST_SCAN, scan_idx_ff <= scan_lim, "scan ran past the table count")
   `DVIL_ASSERT_IMPL(a_hit_bound, state_ff == dvil_pkg::ST_SCAN && hit, chk_ff < scan_lim, "match index beyond the table count")
   `DVIL_ASSERT_NEXT(a_search_start, req_xfer && req_kind[1], state_ff == dvil_pkg::ST_RD_A || state_ff == dvil_pkg::ST_RESP, "accepted search did not start")

endmodule

// ===== sim/tb_difference_vector_index_lookup.sv =====
module tb_difference_vector_index_lookup;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [dvil_pkg::IN_COMP_BITS-1:0] x;
      logic [dvil_pkg::IN_COMP_BITS-1:0] y;
      logic [dvil_pkg::IN_COMP_BITS-1:0] z;
   } vec_type;

   typedef struct {
      logic                          found;
      logic [dvil_pkg::IDX_BITS-1:0] match_idx;
   } lookup_result_type;

   // shadow of both vector tables and the two count registers
   class lookup_scoreboard;
      vec_type                          wave_tbl [dvil_pkg::WAVE_DEPTH_DEF];
      vec_type                          xfer_tbl [dvil_pkg::TRANSFER_DEPTH_DEF];
      logic [dvil_pkg::WCOUNT_BITS-1:0] wave_count = '0;
      logic [dvil_pkg::TCOUNT_BITS-1:0] xfer_count = '0;
      lookup_result_type                expected_results [$];
      int                               errors = 0;

      function int unsigned eff_waves();
         return (wave_count > dvil_pkg::WAVE_DEPTH_DEF) ? dvil_pkg::WAVE_DEPTH_DEF
                                                        : wave_count;
      endfunction

      function int unsigned eff_xfers();
         return (xfer_count > dvil_pkg::TRANSFER_DEPTH_DEF) ? dvil_pkg::TRANSFER_DEPTH_DEF
                                                            : xfer_count;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      function void write_reg(dvil_pkg::csr_idx_type r,
                              logic [dvil_pkg::CSR_DATA_BITS-1:0] d);
         if (r == dvil_pkg::CSR_WAVE_COUNT) begin
            wave_count = d[dvil_pkg::WCOUNT_BITS-1:0];
         end else begin
            xfer_count = d[dvil_pkg::TCOUNT_BITS-1:0];
         end
      endfunction

      function void note_item(dvil_pkg::kind_type k, logic [dvil_pkg::IDX_BITS-1:0] a,
                              logic [dvil_pkg::IDX_BITS-1:0] b, vec_type v);
         lookup_result_type res;
         vec_type           lhs;
         vec_type           rhs;
         vec_type           cand;
         int unsigned       lim;
         int                dx;
         int                dy;
         int                dz;
         bit                in_range;
         case (k)
            dvil_pkg::KIND_LOAD_WAVE: begin
               // slots beyond the table are dropped
               if (a < dvil_pkg::WAVE_DEPTH_DEF) wave_tbl[a] = v;
            end
            dvil_pkg::KIND_LOAD_XFER: begin
               if (a < dvil_pkg::TRANSFER_DEPTH_DEF) xfer_tbl[a] = v;
            end
            default: begin
               res.found = 1'b0;
               res.match_idx = '0;
               if (k == dvil_pkg::KIND_SEARCH_WT) begin
                  in_range = (a < eff_waves()) && (b < eff_xfers());
                  lim = eff_waves();
               end else begin
                  in_range = (a < eff_waves()) && (b < eff_waves());
                  lim = eff_xfers();
               end
               if (in_range) begin
                  lhs = wave_tbl[a];
                  rhs = (k == dvil_pkg::KIND_SEARCH_WT) ? xfer_tbl[b] : wave_tbl[b];
                  // exact difference, may fall outside the component range
                  dx = int'($signed(lhs.x)) - int'($signed(rhs.x));
                  dy = int'($signed(lhs.y)) - int'($signed(rhs.y));
                  dz = int'($signed(lhs.z)) - int'($signed(rhs.z));
                  for (int i = 0; i < lim; i++) begin
                     cand = (k == dvil_pkg::KIND_SEARCH_WT) ? wave_tbl[i] : xfer_tbl[i];
                     if (int'($signed(cand.x)) == dx && int'($signed(cand.y)) == dy &&
                         int'($signed(cand.z)) == dz) begin
                        res.found = 1'b1;
                        res.match_idx = i[dvil_pkg::IDX_BITS-1:0];
                        break;
                     end
                  end
               end
               expected_results.insert(expected_results.size(), res);
            end
         endcase
      endfunction

      function void check_result(logic found, logic [dvil_pkg::IDX_BITS-1:0] idx);
         lookup_result_type exp_res;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transfer: expected none, got found=%0d index=%0d",
                     $time, found, idx);
            errors++;
            return;
         end
         exp_res = expected_results.pop_front();
         if (exp_res.found !== found) begin
            $display("%0t: found mismatch: expected %0d, got %0d", $time, exp_res.found, found);
            errors++;
         end
         if (exp_res.match_idx !== idx) begin
            $display("%0t: match_index mismatch: expected %0d, got %0d",
                     $time, exp_res.match_idx, idx);
            errors++;
         end
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [1:0]                             req_kind;
   logic [dvil_pkg::IDX_BITS-1:0]          req_first_index;
   logic [dvil_pkg::IDX_BITS-1:0]          req_second_index;
   logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_x;
   logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_y;
   logic signed [dvil_pkg::IN_COMP_BITS-1:0] req_comp_z;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic                                   rsp_found;
   logic [dvil_pkg::IDX_BITS-1:0]          rsp_match_index;
   logic                                   csr_write;
   logic [dvil_pkg::CSR_IDX_BITS-1:0]      csr_index;
   logic [dvil_pkg::CSR_DATA_BITS-1:0]     csr_wdata;

   lookup_scoreboard sb = new;
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 63;

   // wave_count, transfer_count pairs; 1023 on the wave register wraps to 127
   int unsigned count_setting [6][2] = '{'{64, 512}, '{1, 1}, '{1023, 1023},
                                         '{17, 45}, '{0, 0}, '{40, 300}};

   difference_vector_index_lookup i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_comp_x       (req_comp_x),
      .req_comp_y       (req_comp_y),
      .req_comp_z       (req_comp_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_index  (rsp_match_index),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_found, rsp_match_index);
   end

   function automatic vec_type make_vec(int x, int y, int z);
      vec_type v;
      v.x = x[dvil_pkg::IN_COMP_BITS-1:0];
      v.y = y[dvil_pkg::IN_COMP_BITS-1:0];
      v.z = z[dvil_pkg::IN_COMP_BITS-1:0];
      return v;
   endfunction

   // mostly small components so that differences land on stored entries
   function automatic int rand_comp();
      if ($urandom_range(7) == 0) return int'($urandom_range(255));
      return int'($urandom_range(4)) - 2;
   endfunction

   function automatic vec_type rand_vec();
      return make_vec(rand_comp(), rand_comp(), rand_comp());
   endfunction

   function automatic logic [dvil_pkg::IDX_BITS-1:0] pick_index(int unsigned lim);
      if (lim == 0 || $urandom_range(9) == 0) begin
         return dvil_pkg::IDX_BITS'($urandom_range(511));
      end
      return dvil_pkg::IDX_BITS'($urandom_range(lim - 1));
   endfunction

   task automatic send_item(dvil_pkg::kind_type k, logic [dvil_pkg::IDX_BITS-1:0] a,
                            logic [dvil_pkg::IDX_BITS-1:0] b, vec_type v);
      int unsigned gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = k;
      req_first_index = a;
      req_second_index = b;
      req_comp_x = v.x;
      req_comp_y = v.y;
      req_comp_z = v.z;
      do @(posedge clock); while (req_stall);
      sb.note_item(k, a, b, v);
   endtask

   // hold off the sender until every pending search has answered
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_register(dvil_pkg::csr_idx_type r,
                                 logic [dvil_pkg::CSR_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = r;
      csr_wdata = d;
      @(negedge clock);
      csr_write = 1'b0;
      sb.write_reg(r, d);
   endtask

   task automatic random_item();
      int unsigned r;
      vec_type     noise;
      r = $urandom_range(99);
      noise = vec_type'(24'($urandom));
      if (r < 20) begin
         send_item(dvil_pkg::KIND_LOAD_WAVE,
                   ($urandom_range(7) == 0) ? dvil_pkg::IDX_BITS'($urandom_range(511))
                                            : dvil_pkg::IDX_BITS'($urandom_range(63)),
                   dvil_pkg::IDX_BITS'($urandom_range(511)), rand_vec());
      end else if (r < 40) begin
         send_item(dvil_pkg::KIND_LOAD_XFER, dvil_pkg::IDX_BITS'($urandom_range(511)),
                   dvil_pkg::IDX_BITS'($urandom_range(511)), rand_vec());
      end else if (r < 70) begin
         send_item(dvil_pkg::KIND_SEARCH_WT, pick_index(sb.eff_waves()),
                   pick_index(sb.eff_xfers()), noise);
      end else begin
         send_item(dvil_pkg::KIND_SEARCH_WW, pick_index(sb.eff_waves()),
                   pick_index(sb.eff_waves()), noise);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = dvil_pkg::KIND_LOAD_WAVE;
      req_first_index = '0;
      req_second_index = '0;
      req_comp_x = '0;
      req_comp_y = '0;
      req_comp_z = '0;
      csr_write = 1'b0;
      csr_index = dvil_pkg::CSR_WAVE_COUNT;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // both counts are zero out of reset: operands out of range, no table reads
      send_item(dvil_pkg::KIND_SEARCH_WT, 0, 0, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WW, 511, 511, make_vec(-1, -1, -1));

      // fill both tables so that no count can reach an unwritten entry
      for (int i = 0; i < dvil_pkg::WAVE_DEPTH_DEF; i++) begin
         send_item(dvil_pkg::KIND_LOAD_WAVE, dvil_pkg::IDX_BITS'(i),
                   dvil_pkg::IDX_BITS'($urandom_range(511)), rand_vec());
      end
      for (int i = 0; i < dvil_pkg::TRANSFER_DEPTH_DEF; i++) begin
         send_item(dvil_pkg::KIND_LOAD_XFER, dvil_pkg::IDX_BITS'(i),
                   dvil_pkg::IDX_BITS'($urandom_range(511)), rand_vec());
      end
      settle();
      write_register(dvil_pkg::CSR_WAVE_COUNT, 64);
      write_register(dvil_pkg::CSR_XFER_COUNT, 512);

      // loads beyond the wave table are dropped
      send_item(dvil_pkg::KIND_LOAD_WAVE, 64, 0, make_vec(127, -128, 127));
      send_item(dvil_pkg::KIND_LOAD_WAVE, 511, 511, make_vec(-128, 127, -128));
      send_item(dvil_pkg::KIND_LOAD_WAVE, 0, 0, make_vec(127, 127, 127));
      send_item(dvil_pkg::KIND_LOAD_WAVE, 1, 0, make_vec(-128, -128, -128));
      send_item(dvil_pkg::KIND_LOAD_WAVE, 2, 0, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_LOAD_WAVE, 63, 0, make_vec(100, 100, 100));
      send_item(dvil_pkg::KIND_LOAD_XFER, 0, 0, make_vec(-1, -1, -1));
      send_item(dvil_pkg::KIND_LOAD_XFER, 5, 0, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_LOAD_XFER, 511, 0, make_vec(100, 100, 100));
      // differences outside the component range never match
      send_item(dvil_pkg::KIND_SEARCH_WT, 0, 0, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WW, 0, 1, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WW, 1, 0, make_vec(0, 0, 0));
      // zero difference, then hits on the last entry of each table
      send_item(dvil_pkg::KIND_SEARCH_WW, 2, 2, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WT, 63, 5, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WW, 63, 2, make_vec(0, 0, 0));
      // operand indexes past the counts
      send_item(dvil_pkg::KIND_SEARCH_WT, 64, 0, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WW, 2, 511, make_vec(0, 0, 0));
      send_item(dvil_pkg::KIND_SEARCH_WT, 511, 511, make_vec(-128, -128, -128));

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 63 : 0;
         recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 36 : 0;
         for (int s = 0; s < 6; s++) begin
            settle();
            write_register(dvil_pkg::CSR_WAVE_COUNT,
                           dvil_pkg::CSR_DATA_BITS'(count_setting[s][0]));
            write_register(dvil_pkg::CSR_XFER_COUNT,
                           dvil_pkg::CSR_DATA_BITS'(count_setting[s][1]));
            repeat (33) random_item();
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/dvil_pkg.sv
rtl/core/dvil_ram.sv
rtl/core/difference_vector_index_lookup.sv
sim/tb_difference_vector_index_lookup.sv
